>>> src/tpc_pkg.sv
package tpc_pkg;

    // sample and pixel widths
    localparam int SAMPLE_BITS = 12;
    localparam int PIXEL_BITS  = 12;

    // largest allowed move between the two sample pairs
    localparam int STABLE_LIMIT = 100;

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = (SAMPLE_BITS > PIXEL_BITS) ? SAMPLE_BITS : PIXEL_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_CAL_MIN_X     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CAL_MAX_X     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CAL_MIN_Y     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CAL_MAX_Y     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VALID_LOW     = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VALID_HIGH    = 3'd7;

    // arithmetic widths: signed offset times size, quotient magnitude
    localparam int DEN_W = SAMPLE_BITS + 1;
    localparam int NUM_W = SAMPLE_BITS + PIXEL_BITS + 2;
    localparam int QUO_W = SAMPLE_BITS + PIXEL_BITS;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // one axis of a classified report
    typedef struct packed {
        logic signed [NUM_W-1:0] num;
        logic signed [DEN_W-1:0] den;
        logic [PIXEL_BITS-1:0]   size;
    } axis_job_t;

    // one classified report
    typedef struct packed {
        logic      ok;
        axis_job_t x;
        axis_job_t y;
    } job_t;

endpackage

>>> src/tpc_front.sv
module tpc_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tpc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [tpc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 touch_active,
    input  logic [tpc_pkg::SAMPLE_BITS-1:0]      first_x,
    input  logic [tpc_pkg::SAMPLE_BITS-1:0]      first_y,
    input  logic [tpc_pkg::SAMPLE_BITS-1:0]      second_x,
    input  logic [tpc_pkg::SAMPLE_BITS-1:0]      second_y,
    output tpc_pkg::job_t                        job
);
    import tpc_pkg::*;

    logic [SAMPLE_BITS-1:0] cal_min_x_reg, cal_max_x_reg, cal_min_y_reg, cal_max_y_reg;
    logic [SAMPLE_BITS-1:0] valid_low_reg, valid_high_reg;
    logic [PIXEL_BITS-1:0]  screen_width_reg, screen_height_reg;

    logic [SAMPLE_BITS-1:0] diff_x, diff_y;
    logic                   stable, in_window;
    logic signed [DEN_W-1:0] off_x, off_y;
    logic signed [PIXEL_BITS:0] size_x, size_y;

    // take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_min_x_reg     <= SAMPLE_BITS'(200);
            cal_max_x_reg     <= SAMPLE_BITS'(3900);
            cal_min_y_reg     <= SAMPLE_BITS'(200);
            cal_max_y_reg     <= SAMPLE_BITS'(3900);
            screen_width_reg  <= PIXEL_BITS'(320);
            screen_height_reg <= PIXEL_BITS'(240);
            valid_low_reg     <= SAMPLE_BITS'(200);
            valid_high_reg    <= SAMPLE_BITS'(4000);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CAL_MIN_X:     cal_min_x_reg     <= cfg_data[SAMPLE_BITS-1:0];
                REG_CAL_MAX_X:     cal_max_x_reg     <= cfg_data[SAMPLE_BITS-1:0];
                REG_CAL_MIN_Y:     cal_min_y_reg     <= cfg_data[SAMPLE_BITS-1:0];
                REG_CAL_MAX_Y:     cal_max_y_reg     <= cfg_data[SAMPLE_BITS-1:0];
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[PIXEL_BITS-1:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[PIXEL_BITS-1:0];
                REG_VALID_LOW:     valid_low_reg     <= cfg_data[SAMPLE_BITS-1:0];
                REG_VALID_HIGH:    valid_high_reg    <= cfg_data[SAMPLE_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // classify the report: stable pair, first pair inside the window;
    // form numerators and spans for the divider
    always_comb
    begin
        diff_x = (first_x > second_x) ? first_x - second_x : second_x - first_x;
        diff_y = (first_y > second_y) ? first_y - second_y : second_y - first_y;
        stable = (diff_x <= SAMPLE_BITS'(STABLE_LIMIT)) &&
                 (diff_y <= SAMPLE_BITS'(STABLE_LIMIT));
        in_window = (first_x <= valid_high_reg) && (first_y <= valid_high_reg) &&
                    (first_x >= valid_low_reg) && (first_y >= valid_low_reg);
        job.ok = touch_active && stable && in_window;

        off_x  = $signed({1'b0, first_x}) - $signed({1'b0, cal_min_x_reg});
        off_y  = $signed({1'b0, first_y}) - $signed({1'b0, cal_min_y_reg});
        size_x = $signed({1'b0, screen_width_reg});
        size_y = $signed({1'b0, screen_height_reg});
        job.x.num  = NUM_W'(off_x * size_x);
        job.y.num  = NUM_W'(off_y * size_y);
        job.x.den  = $signed({1'b0, cal_max_x_reg}) - $signed({1'b0, cal_min_x_reg});
        job.y.den  = $signed({1'b0, cal_max_y_reg}) - $signed({1'b0, cal_min_y_reg});
        job.x.size = screen_width_reg;
        job.y.size = screen_height_reg;
    end

endmodule

>>> src/tpc_queue.sv
module tpc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  tpc_pkg::job_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output tpc_pkg::job_t rd_data,
    output logic          empty
);
    import tpc_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

    // store the incoming beat
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

>>> src/tpc_back.sv
module tpc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tpc_pkg::job_t                 job,
    input  logic                          job_empty,
    output logic                          job_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic                          pressed,
    output logic [tpc_pkg::PIXEL_BITS-1:0] screen_x,
    output logic [tpc_pkg::PIXEL_BITS-1:0] screen_y
);
    import tpc_pkg::*;

    localparam int V_W = QUO_W + 2;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] rem;
        logic [QUO_W-1:0]       nq;
        logic [SAMPLE_BITS-1:0] dmag;
        logic                   neg;
        logic                   dz;
        logic                   nz;
        logic [PIXEL_BITS-1:0]  size;
    } axis_st_t;

    typedef struct packed {
        logic     ok;
        axis_st_t x;
        axis_st_t y;
    } stage_t;

    // split signs off and set up a division
    function automatic axis_st_t div_load(axis_job_t j);
        axis_st_t         r;
        logic [NUM_W-1:0] num_abs;
        logic [DEN_W-1:0] den_abs;
        num_abs = j.num[NUM_W-1] ? NUM_W'(-j.num) : NUM_W'(j.num);
        den_abs = j.den[DEN_W-1] ? DEN_W'(-j.den) : DEN_W'(j.den);
        r.rem  = '0;
        r.nq   = num_abs[QUO_W-1:0];
        r.dmag = den_abs[SAMPLE_BITS-1:0];
        r.neg  = j.num[NUM_W-1] ^ j.den[DEN_W-1];
        r.dz   = (j.den == '0);
        r.nz   = (j.num != '0);
        r.size = j.size;
        return r;
    endfunction

    // one restoring step: one quotient bit
    function automatic axis_st_t div_step(axis_st_t a);
        axis_st_t           r;
        logic [SAMPLE_BITS:0] t;
        r = a;
        t = {a.rem, a.nq[QUO_W-1]};
        if (t >= {1'b0, a.dmag})
        begin
            r.rem = SAMPLE_BITS'(t - {1'b0, a.dmag});
            r.nq  = {a.nq[QUO_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = t[SAMPLE_BITS-1:0];
            r.nq  = {a.nq[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // quotient magnitude, saturated on a zero span
    function automatic logic [QUO_W-1:0] quo_mag(axis_st_t a);
        if (a.dz)
            return a.nz ? {QUO_W{1'b1}} : '0;
        return a.nq;
    endfunction

    // inverted axis: size minus quotient, clamped
    function automatic logic [PIXEL_BITS-1:0] map_x(axis_st_t a);
        logic [QUO_W-1:0]     mag;
        logic signed [V_W-1:0] v, sz;
        mag = quo_mag(a);
        sz  = $signed(V_W'(a.size));
        v   = a.neg ? sz + $signed(V_W'(mag)) : sz - $signed(V_W'(mag));
        if (a.size == '0)
            return '0;
        if (v[V_W-1])
            return '0;
        if (v >= sz)
            return a.size - 1'b1;
        return v[PIXEL_BITS-1:0];
    endfunction

    // direct axis: quotient, clamped
    function automatic logic [PIXEL_BITS-1:0] map_y(axis_st_t a);
        logic [QUO_W-1:0] mag;
        mag = quo_mag(a);
        if (a.size == '0 || a.neg)
            return '0;
        if (mag >= QUO_W'(a.size))
            return a.size - 1'b1;
        return mag[PIXEL_BITS-1:0];
    endfunction

    stage_t              st_reg [QUO_W+1];
    logic [QUO_W:0]      vld_reg;
    logic                out_vld_reg;
    logic                pressed_reg;
    logic [PIXEL_BITS-1:0] screen_x_reg, screen_y_reg;
    logic                adv;

    // the pipeline moves whenever the output slot is free or being taken
    assign adv      = !out_vld_reg || pop;
    assign job_pop  = adv && !job_empty;
    assign empty    = !out_vld_reg;
    assign pressed  = pressed_reg;
    assign screen_x = screen_x_reg;
    assign screen_y = screen_y_reg;

    // advance stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[QUO_W-1:0], !job_empty};
            out_vld_reg <= vld_reg[QUO_W];
        end
    end

    // advance the divider stages and form the result
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0].ok <= job.ok;
            st_reg[0].x  <= div_load(job.x);
            st_reg[0].y  <= div_load(job.y);
            for (int k = 0; k < QUO_W; k++)
            begin
                st_reg[k+1].ok <= st_reg[k].ok;
                st_reg[k+1].x  <= div_step(st_reg[k].x);
                st_reg[k+1].y  <= div_step(st_reg[k].y);
            end
            pressed_reg  <= st_reg[QUO_W].ok;
            screen_x_reg <= st_reg[QUO_W].ok ? map_x(st_reg[QUO_W].x) : '0;
            screen_y_reg <= st_reg[QUO_W].ok ? map_y(st_reg[QUO_W].y) : '0;
        end
    end

endmodule

>>> src/touch_point_calibrate.sv
// Touch point calibration. Each beat on the input side is one touch report
// (pen flag and two raw X/Y sample pairs); each report gives exactly one
// result beat, in order. A report with no touch, with either axis moving by
// more than 100 counts between pairs, or with the first pair outside
// valid_low..valid_high, comes out with pressed, screen_x and screen_y all 0.
// Otherwise the first pair is mapped through the calibration window (X
// inverted), truncated toward zero and clamped to 0..size-1; a zero span
// saturates to the matching screen edge. One report is taken every cycle
// while full is low; each result passes through the queue slot, the load
// register, the one-bit-per-stage divider (24 stages) and the output
// register. A four-beat queue sits between the classifier and the
// divider, so push keeps going while a result waits to be popped until that
// queue fills.
// Write configuration registers only while the block holds no reports.
module touch_point_calibrate (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tpc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [tpc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 touch_active,
    input  logic [tpc_pkg::SAMPLE_BITS-1:0]      first_x,
    input  logic [tpc_pkg::SAMPLE_BITS-1:0]      first_y,
    input  logic [tpc_pkg::SAMPLE_BITS-1:0]      second_x,
    input  logic [tpc_pkg::SAMPLE_BITS-1:0]      second_y,
    output logic                                 empty,
    input  logic                                 pop,
    output logic                                 pressed,
    output logic [tpc_pkg::PIXEL_BITS-1:0]       screen_x,
    output logic [tpc_pkg::PIXEL_BITS-1:0]       screen_y
);
    import tpc_pkg::*;

    job_t front_job, queue_job;
    logic queue_empty, queue_pop;

    // classify reports and hold configuration
    tpc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .touch_active (touch_active),
        .first_x      (first_x),
        .first_y      (first_y),
        .second_x     (second_x),
        .second_y     (second_y),
        .job          (front_job)
    );

    // hold classified beats until the divider takes them
    tpc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && !full),
        .wr_data (front_job),
        .full    (full),
        .rd_en   (queue_pop),
        .rd_data (queue_job),
        .empty   (queue_empty)
    );

    // divide, clamp and present results
    tpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (queue_job),
        .job_empty (queue_empty),
        .job_pop   (queue_pop),
        .empty     (empty),
        .pop       (pop),
        .pressed   (pressed),
        .screen_x  (screen_x),
        .screen_y  (screen_y)
    );

endmodule
